@@ src/cmdi_pkg.sv @@
`timescale 1ns / 1ps

package cmdi_pkg;

    // Item kinds carried in the input tuser
    localparam logic [2:0] FN_CLEAR  = 3'd0;
    localparam logic [2:0] FN_DEPOSIT = 3'd1;
    localparam logic [2:0] FN_INTERP = 3'd2;
    localparam logic [2:0] FN_WRITE  = 3'd3;
    localparam logic [2:0] FN_READ   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_SCALE_INV   = 2'd0;
    localparam logic [1:0] CFG_MASS_FACTOR = 2'd1;
    localparam logic [1:0] CFG_SLAB_START  = 2'd2;
    localparam logic [1:0] CFG_SLAB_COUNT  = 2'd3;

    localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [31:0] CLEAR_VAL = 32'hFFFF_0000; // -1.0 in Q16.16

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 40;

    // Sequencer states, one-hot
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_CLEAR = 11'b000_0000_0010,
        ST_SMUL  = 11'b000_0000_0100,
        ST_SCAP  = 11'b000_0000_1000,
        ST_CW1   = 11'b000_0001_0000,
        ST_CW2   = 11'b000_0010_0000,
        ST_CW3   = 11'b000_0100_0000,
        ST_CACC  = 11'b000_1000_0000,
        ST_CELL  = 11'b001_0000_0000,
        ST_RDCAP = 11'b010_0000_0000,
        ST_FIN   = 11'b100_0000_0000
    } state_t;

endpackage

@@ src/cmdi_mesh.sv @@
`timescale 1ns / 1ps

module cmdi_mesh #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ src/cic_mesh_deposit_interpolate_core.sv @@
`timescale 1ns / 1ps

// Clear: writes every one of the NC^3 mesh cells, one memory write a cycle.
// Deposit / interpolate: axis split on the shared multiplier (SMUL, SCAP per axis),
// then CW1, CW2, CW3, CACC per corner in the slab (only CW1 for a skipped corner), FIN.
// Write cell: CELL, FIN; read: CELL, RDCAP, FIN; other kinds: FIN; one item at a time.
// Reset idles control and restores default configuration; mesh undefined until cleared.
module cic_mesh_deposit_interpolate_core #(
    parameter int NC = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, cell_x, cell_y, cell_z, cell_value, component, pad
    input  logic [cmdi_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // func
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // value, component_out, pad
    output logic [cmdi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // saturated
    output logic         m_axis_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    import cmdi_pkg::*;

    localparam int CW    = $clog2(NC);
    localparam int DEPTH = NC * NC * NC;
    localparam int AW    = $clog2(DEPTH);

    // Configuration
    logic [31:0] scale_inv_reg, mass_factor_reg;
    logic [3:0]  slab_start_reg;
    logic [4:0]  slab_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_inv_reg   <= ONE_Q16;
            mass_factor_reg <= ONE_Q16;
            slab_start_reg  <= '0;
            slab_count_reg  <= 5'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SCALE_INV:   scale_inv_reg   <= cfg_wdata;
                CFG_MASS_FACTOR: mass_factor_reg <= cfg_wdata;
                CFG_SLAB_START:  slab_start_reg  <= cfg_wdata[3:0];
                CFG_SLAB_COUNT:  slab_count_reg  <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // Latched input word
    logic [2:0]  func_reg;
    logic [31:0] pos_reg [3];
    logic [3:0]  cx_reg, cy_reg, cz_reg;
    logic [31:0] cval_reg;
    logic [1:0]  comp_reg;

    // Axis split results
    logic [CW-1:0] lo_reg [3];
    logic [CW-1:0] hi_reg [3];
    logic [15:0]   frac_reg [3];
    logic [1:0]    ax_reg;
    logic [2:0]    corner_reg;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg;
    logic signed [50:0] acc_reg;
    logic sat_reg;
    logic [31:0] res_val_reg;
    logic m_valid_reg;
    logic [31:0] m_value_reg;
    logic [1:0]  m_comp_reg;
    logic        m_sat_reg;

    // Shared multiplier, registered product
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_q;

    always_ff @(posedge clk)
    begin
        mul_q <= mul_a * mul_b;
    end

    // Mesh memory
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [31:0]   mem_wd, mem_q;

    cmdi_mesh #(.DEPTH(DEPTH), .AW(AW)) u_mesh (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wd),
        .rdata (mem_q)
    );

    // Corner selection
    logic          ca, cb, cc;
    logic [CW-1:0] gx, gy, gz;
    logic [7:0]    dx;
    logic          plane_ok;
    logic [16:0]   wx, wy, wz;
    logic [AW-1:0] corner_addr, cell_addr;
    logic          cell_ok;

    assign ca = corner_reg[2];
    assign cb = corner_reg[1];
    assign cc = corner_reg[0];
    assign gx = ca ? hi_reg[0] : lo_reg[0];
    assign gy = cb ? hi_reg[1] : lo_reg[1];
    assign gz = cc ? hi_reg[2] : lo_reg[2];
    assign dx = 8'(gx) - 8'(slab_start_reg);
    assign plane_ok = (8'(gx) >= 8'(slab_start_reg)) && (dx < 8'(slab_count_reg))
                      && (32'(dx) < NC);
    assign wx = ca ? 17'(frac_reg[0]) : 17'(ONE_Q16) - 17'(frac_reg[0]);
    assign wy = cb ? 17'(frac_reg[1]) : 17'(ONE_Q16) - 17'(frac_reg[1]);
    assign wz = cc ? 17'(frac_reg[2]) : 17'(ONE_Q16) - 17'(frac_reg[2]);
    assign corner_addr = AW'(32'(dx) * NC * NC + 32'(gy) * NC + 32'(gz));
    assign cell_addr   = AW'(32'(cx_reg) * NC * NC + 32'(cy_reg) * NC + 32'(cz_reg));
    assign cell_ok = (32'(cx_reg) < NC) && (32'(cy_reg) < NC) && (32'(cz_reg) < NC);

    // Axis split of the fresh product
    logic [31:0]   g_int;
    logic [CW-1:0] lo_new, hi_new;

    assign g_int  = mul_q[63:32];
    assign lo_new = (g_int >= 32'(NC)) ? '0 : g_int[CW-1:0];
    assign hi_new = (32'(lo_new) + 1 >= NC) ? '0 : lo_new + 1'b1;

    // Deposit update and interpolation result
    logic signed [33:0] dep_sum;
    logic [31:0]        dep_val;
    logic               dep_sat;
    logic signed [34:0] q_sh;
    logic [31:0]        int_val;
    logic               int_sat;

    assign dep_sum = 34'(signed'(mem_q)) + signed'({1'b0, mul_q[48:16]});
    assign dep_sat = dep_sum > 34'sh0_7FFF_FFFF;
    assign dep_val = dep_sat ? 32'h7FFF_FFFF : dep_sum[31:0];
    assign q_sh    = 35'(acc_reg >>> 16);
    always_comb
    begin
        int_sat = 1'b1;
        int_val = 32'h7FFF_FFFF;
        if (q_sh < -35'sh0_8000_0000)
        begin
            int_val = 32'h8000_0000;
        end
        else if (q_sh <= 35'sh0_7FFF_FFFF)
        begin
            int_sat = 1'b0;
            int_val = q_sh[31:0];
        end
    end

    // Multiplier operands and memory port
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        mem_we   = 1'b0;
        mem_addr = corner_addr;
        mem_wd   = dep_val;
        case (state_reg)
            ST_SMUL:
            begin
                mul_a = signed'({2'b00, pos_reg[ax_reg]});
                mul_b = signed'({2'b00, scale_inv_reg});
            end
            ST_CW1:
            begin
                mul_a = signed'(34'(wx));
                mul_b = signed'(34'(wy));
            end
            ST_CW2:
            begin
                mul_a = signed'({1'b0, mul_q[32:0]});
                mul_b = signed'(34'(wz));
            end
            ST_CW3:
            begin
                mul_a = signed'(34'(mul_q[48:32]));
                mul_b = (func_reg == FN_DEPOSIT) ? signed'({2'b00, mass_factor_reg})
                                                 : 34'(signed'(mem_q));
            end
            ST_CACC:
            begin
                mem_we = (func_reg == FN_DEPOSIT);
            end
            ST_CLEAR:
            begin
                mem_addr = clr_reg;
                mem_wd   = CLEAR_VAL;
                mem_we   = 1'b1;
            end
            ST_CELL:
            begin
                mem_addr = cell_addr;
                mem_wd   = cval_reg;
                mem_we   = (func_reg == FN_WRITE) && cell_ok;
            end
            default: ;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (s_axis_tuser)
                        FN_CLEAR:            state_next = ST_CLEAR;
                        FN_DEPOSIT, FN_INTERP: state_next = ST_SMUL;
                        FN_WRITE, FN_READ:   state_next = ST_CELL;
                        default:             state_next = ST_FIN;
                    endcase
                end
            end
            ST_CLEAR: if (32'(clr_reg) == DEPTH - 1) state_next = ST_FIN;
            ST_SMUL:  state_next = ST_SCAP;
            ST_SCAP:  state_next = (ax_reg == 2'd2) ? ST_CW1 : ST_SMUL;
            ST_CW1:
            begin
                if (plane_ok)
                begin
                    state_next = ST_CW2;
                end
                else if (corner_reg == 3'd7)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_CW2:   state_next = ST_CW3;
            ST_CW3:   state_next = ST_CACC;
            ST_CACC:  state_next = (corner_reg == 3'd7) ? ST_FIN : ST_CW1;
            ST_CELL:  state_next = (func_reg == FN_READ) ? ST_RDCAP : ST_FIN;
            ST_RDCAP: state_next = ST_FIN;
            ST_FIN:   if (!m_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && (!m_valid_reg || m_axis_tready))
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                func_reg    <= s_axis_tuser;
                pos_reg[0]  <= s_axis_tdata[31:0];
                pos_reg[1]  <= s_axis_tdata[63:32];
                pos_reg[2]  <= s_axis_tdata[95:64];
                cx_reg      <= s_axis_tdata[99:96];
                cy_reg      <= s_axis_tdata[103:100];
                cz_reg      <= s_axis_tdata[107:104];
                cval_reg    <= s_axis_tdata[139:108];
                comp_reg    <= s_axis_tdata[141:140];
                ax_reg      <= '0;
                corner_reg  <= '0;
                clr_reg     <= '0;
                acc_reg     <= '0;
                sat_reg     <= 1'b0;
                res_val_reg <= '0;
            end
            ST_CLEAR: clr_reg <= clr_reg + 1'b1;
            ST_SCAP:
            begin
                lo_reg[ax_reg]   <= lo_new;
                hi_reg[ax_reg]   <= hi_new;
                frac_reg[ax_reg] <= mul_q[31:16];
                ax_reg           <= ax_reg + 1'b1;
            end
            ST_CW1:   if (!plane_ok) corner_reg <= corner_reg + 1'b1;
            ST_CACC:
            begin
                corner_reg <= corner_reg + 1'b1;
                if (func_reg == FN_DEPOSIT)
                begin
                    sat_reg <= sat_reg | dep_sat;
                end
                else
                begin
                    acc_reg <= acc_reg + 51'(signed'(mul_q[48:0]));
                end
            end
            ST_RDCAP: res_val_reg <= cell_ok ? mem_q : '0;
            ST_FIN:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_comp_reg  <= comp_reg;
                    m_value_reg <= (func_reg == FN_INTERP) ? int_val : res_val_reg;
                    m_sat_reg   <= (func_reg == FN_INTERP) ? int_sat :
                                   (func_reg == FN_DEPOSIT) ? sat_reg : 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'd0, m_comp_reg, m_value_reg};
    assign m_axis_tuser  = m_sat_reg;

endmodule

@@ src/cmdi_chk.sv @@
`timescale 1ns / 1ps

module cmdi_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // Not ready in the cycle after taking a word
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while still busy");

    // No result appears in the cycle right after a word is taken
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

    // Padding above the component tag is zero on a fresh result
    a_comp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> m_axis_tdata[39:34] == 6'd0)
        else $error("output padding not zero");

endmodule

bind cic_mesh_deposit_interpolate_core cmdi_chk u_cmdi_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
